// ----- rtl/bb3_pkg.sv -----
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, constants and the reciprocal table of the 3x3 box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int PIX_W   = 24;
    localparam int CH_W    = 8;
    localparam int WID_W   = 11;
    localparam int HGT_W   = 13;
    localparam int CFG_W   = 13;
    localparam int OROW_W  = 12;
    localparam int OCOL_W  = 10;
    localparam int ODATA_W = 48;
    localparam int SUM_W   = 12;
    localparam int CNT_W   = 4;
    localparam int NUM_W   = 13;
    localparam int RCP_W   = 16;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // result kinds, in emission order
    localparam logic [1:0] KIND_UL = 2'd0;  // row-1, col-1
    localparam logic [1:0] KIND_UR = 2'd1;  // row-1, col (right edge)
    localparam logic [1:0] KIND_LL = 2'd2;  // row,   col-1 (last row)
    localparam logic [1:0] KIND_LR = 2'd3;  // row,   col (frame end)

    typedef struct packed {
        logic accept;
        logic shift;
        logic sum;
        logic mul;
        logic load;
    } bb3_cmd_t;

    typedef struct packed {
        logic has_work;
        logic out_free;
    } bb3_sts_t;

    // floor(65536 / (2*cnt)); quotient estimate is low by at most one
    function automatic logic [RCP_W-1:0] bb3_recip(input logic [CNT_W-1:0] cnt);
        logic [RCP_W-1:0] r;
        case (cnt)
            4'd1:    r = 16'd32768;
            4'd2:    r = 16'd16384;
            4'd3:    r = 16'd10922;
            4'd4:    r = 16'd8192;
            4'd5:    r = 16'd6553;
            4'd6:    r = 16'd5461;
            4'd7:    r = 16'd4681;
            4'd8:    r = 16'd4096;
            4'd9:    r = 16'd3640;
            default: r = 16'd32768;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/bb3_ctrl.sv -----
// ----------------------------------------------------------------------------
// bb3_ctrl
// Sequencer: takes a pixel, updates the window, then walks the pending
// results through sum, multiply and correct/load steps.
// ----------------------------------------------------------------------------
module bb3_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  bb3_pkg::bb3_sts_t sts,
    output logic              in_ready,
    output bb3_pkg::bb3_cmd_t cmd
);
    import bb3_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_SUM,
        S_MUL,
        S_FIX
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                    state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.shift  = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (sts.has_work)
                begin
                    cmd.sum    = 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_FIX;
            end
            S_FIX:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SUM;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/bb3_dp.sv -----
// ----------------------------------------------------------------------------
// bb3_dp
// Datapath: line stores, 3x3 window, counters, masked sums, reciprocal
// divide and the output register.
// ----------------------------------------------------------------------------
module bb3_dp
#(
    parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  bb3_pkg::bb3_cmd_t           cmd,
    output bb3_pkg::bb3_sts_t           sts,
    input  logic                        cfg_wen,
    input  logic                        cfg_addr,
    input  logic [bb3_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic [bb3_pkg::PIX_W-1:0]   in_pix,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bb3_pkg::ODATA_W-1:0] out_data,
    output logic                        out_last,
    output logic                        out_fend
);
    import bb3_pkg::*;

    localparam int COL_W = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // configuration
    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;

    always_comb
    begin
        if (width_reg == '0)
            col_last = '0;
        else if (32'(width_reg) > MAX_WIDTH)
            col_last = COL_W'(MAX_WIDTH - 1);
        else
            col_last = COL_W'(32'(width_reg) - 32'd1);
        if (height_reg == '0)
            row_last = '0;
        else if (32'(height_reg) > MAX_HEIGHT)
            row_last = ROW_W'(MAX_HEIGHT - 1);
        else
            row_last = ROW_W'(32'(height_reg) - 32'd1);
    end

    // position counters
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] pc_reg;
    logic [ROW_W-1:0] pr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WID_W'(1);
            height_reg <= HGT_W'(1);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_wen)
        begin
            if (cfg_addr == REG_WIDTH)
                width_reg <= cfg_wdata[WID_W-1:0];
            else
                height_reg <= cfg_wdata;
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (col_reg >= col_last)
            begin
                col_reg <= '0;
                row_reg <= (row_reg >= row_last) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // line stores
    logic [PIX_W-1:0] mem_one [MAX_WIDTH];
    logic [PIX_W-1:0] mem_two [MAX_WIDTH];
    logic [PIX_W-1:0] rd_one_reg;
    logic [PIX_W-1:0] rd_two_reg;
    logic [PIX_W-1:0] pix_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_one_reg <= mem_one[col_reg];
            rd_two_reg <= mem_two[col_reg];
            pix_reg    <= in_pix;
            pc_reg     <= col_reg;
            pr_reg     <= row_reg;
        end
        if (cmd.shift)
        begin
            mem_one[pc_reg] <= pix_reg;
            mem_two[pc_reg] <= rd_one_reg;
        end
    end

    // window, index row*3+col; pending result mask
    logic [PIX_W-1:0] win_reg [9];
    logic [3:0]       pend_reg;
    logic [3:0]       pend_next;
    logic [1:0]       kind;

    always_comb
    begin
        if (pend_reg[0])
            kind = KIND_UL;
        else if (pend_reg[1])
            kind = KIND_UR;
        else if (pend_reg[2])
            kind = KIND_LL;
        else
            kind = KIND_LR;
        pend_next = pend_reg;
        pend_next[kind] = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
            pend_reg <= '0;
        end
        else if (cmd.shift)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i*3]   <= win_reg[i*3+1];
                win_reg[i*3+1] <= win_reg[i*3+2];
            end
            win_reg[2] <= rd_two_reg;
            win_reg[5] <= rd_one_reg;
            win_reg[8] <= pix_reg;
            pend_reg[0] <= (pr_reg != '0) && (pc_reg != '0);
            pend_reg[1] <= (pr_reg != '0) && (pc_reg == col_last);
            pend_reg[2] <= (pr_reg == row_last) && (pc_reg != '0);
            pend_reg[3] <= (pr_reg == row_last) && (pc_reg == col_last);
        end
        else if (cmd.sum)
        begin
            pend_reg <= pend_next;
        end
    end

    // masked sums
    logic [2:0]       row_en;
    logic [2:0]       col_en;
    logic [SUM_W-1:0] sum_c [3];
    logic [CNT_W-1:0] cnt_c;

    always_comb
    begin
        row_en[2] = 1'b1;
        row_en[1] = (pr_reg != '0);
        row_en[0] = (pr_reg > ROW_W'(1)) && (kind == KIND_UL || kind == KIND_UR);
        col_en[2] = 1'b1;
        col_en[1] = (pc_reg != '0);
        col_en[0] = (pc_reg > COL_W'(1)) && (kind == KIND_UL || kind == KIND_LL);
        cnt_c = '0;
        for (int k = 0; k < 3; k++)
            sum_c[k] = '0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                if (row_en[i] && col_en[j])
                begin
                    cnt_c = cnt_c + 1'b1;
                    for (int k = 0; k < 3; k++)
                        sum_c[k] = sum_c[k]
                                 + SUM_W'(win_reg[i*3+j][PIX_W-1-k*CH_W -: CH_W]);
                end
    end

    logic [NUM_W-1:0]  num_reg [3];
    logic [CNT_W-1:0]  cnt_reg;
    logic [OROW_W-1:0] orow_reg;
    logic [OCOL_W-1:0] ocol_reg;
    logic              last_reg;
    logic              fend_reg;
    logic [CH_W-1:0]   q0_reg [3];

    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            for (int k = 0; k < 3; k++)
                num_reg[k] <= {sum_c[k], 1'b0} + NUM_W'(cnt_c);
            cnt_reg  <= cnt_c;
            last_reg <= (pend_next == '0);
            fend_reg <= (kind == KIND_LR);
            orow_reg <= (kind == KIND_UL || kind == KIND_UR)
                      ? OROW_W'(pr_reg - 1'b1) : OROW_W'(pr_reg);
            ocol_reg <= (kind == KIND_UL || kind == KIND_LL)
                      ? OCOL_W'(pc_reg - 1'b1) : OCOL_W'(pc_reg);
        end
        if (cmd.mul)
        begin
            for (int k = 0; k < 3; k++)
                q0_reg[k] <= 8'((32'(num_reg[k]) * 32'(bb3_recip(cnt_reg))) >> RCP_W);
        end
    end

    // correction: estimate is exact or one low
    logic [4:0]       div_c;
    logic [NUM_W-1:0] rem_c [3];
    logic [CH_W-1:0]  q_c [3];

    always_comb
    begin
        div_c = {cnt_reg, 1'b0};
        for (int k = 0; k < 3; k++)
        begin
            rem_c[k] = num_reg[k] - NUM_W'(q0_reg[k]) * NUM_W'(div_c);
            q_c[k]   = (rem_c[k] >= NUM_W'(div_c)) ? q0_reg[k] + 1'b1 : q0_reg[k];
        end
    end

    // output register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_data <= {2'b00, ocol_reg, orow_reg, q_c[2], q_c[1], q_c[0]};
            out_last <= last_reg;
            out_fend <= fend_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sts.out_free = !out_valid_reg || out_ready;
    assign sts.has_work = (pend_reg != '0);

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken result");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> (pend_reg == '0))
        else $error("pixel accepted with results pending");
    a_sum_work: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum |=> ($countones(pend_reg) == $countones($past(pend_reg)) - 1))
        else $error("pending mask not reduced by one");
`endif

endmodule

// ----- rtl/box_blur_3x3_edge_aware.sv -----
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware
// 3x3 box blur of a raster RGB stream, mean over in-frame neighbors only.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel per request in raster order. m_axis carries the
//   blurred pixels, each tagged with its row and column; tlast marks the last
//   result caused by one input pixel, tuser the last pixel of the frame.
//   A result leaves as soon as its 3x3 neighborhood has arrived, so one input
//   pixel yields zero to four results.
//   cfg_wen/cfg_addr/cfg_wdata set width (0) and height (1); any write
//   restarts the frame. Write only while the block is idle.
// Sequence:
//   A pixel passes through accept with line store read, window update and
//   pending check, plus sum, reciprocal multiply, and correct and load for
//   each result it completes; the load waits while the output register is
//   full. The shared sum/divide path takes the results one after another.
//   m_axis_tvalid rises when the pixel's first result is loaded.
// Reset clears counters, window and output valid; line stores are not
// cleared. While m_axis stalls, the finished result waits in the output
// register and the sequencer holds the next one ready behind it.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware
#(
    parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [bb3_pkg::PIX_W-1:0]   s_axis_tdata,   // in_red, in_green, in_blue
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // out_red, out_green, out_blue, out_row, out_col, 2 zero bits
    output logic [bb3_pkg::ODATA_W-1:0] m_axis_tdata,
    output logic                        m_axis_tlast,   // run_last
    output logic                        m_axis_tuser,   // frame_end
    input  logic                        cfg_wen,
    input  logic                        cfg_addr,
    input  logic [bb3_pkg::CFG_W-1:0]   cfg_wdata
);
    import bb3_pkg::*;

    bb3_cmd_t cmd;
    bb3_sts_t sts;

    bb3_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .sts      (sts),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    bb3_dp
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_pix    ({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]}),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_fend  (m_axis_tuser)
    );

endmodule

// ----- test/tb_box_blur_3x3_edge_aware.sv -----
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_edge_aware
// Self-checking bench for the edge-aware 3x3 box blur.
// ----------------------------------------------------------------------------
// Pixels go in as s_axis requests. Each accepted pixel runs through a local
// blur model: line stores, window, counters and geometry registers. That
// model queues the blurred pixels the request completes, and every m_axis
// result is checked field by field against the oldest one in the queue.
// Directed frames cover corners, edges, single-row and single-column frames
// and clamped geometry. Random frames of random size follow, under three
// idling mixes. Geometry changes only while the block is idle.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_edge_aware;
    import bb3_pkg::*;

    localparam int WDOG_LIMIT  = 5000;  // cycles with no handshake on either side
    localparam int DRAIN_WAIT  = 20;    // settling margin after the last result
    localparam int PHASE_ITEMS = 100;

    typedef struct packed {
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic [OROW_W-1:0] row;
        logic [OCOL_W-1:0] col;
        logic              run_last;
        logic              frame_end;
    } blur_px_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [PIX_W-1:0]    s_axis_tdata = '0;    // in_red, in_green, in_blue
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // out_red, out_green, out_blue, out_row, out_col, 2 zero bits
    logic [ODATA_W-1:0]  m_axis_tdata;
    logic                m_axis_tlast;         // run_last
    logic                m_axis_tuser;         // frame_end
    logic                cfg_wen = 1'b0;
    logic                cfg_addr = REG_WIDTH;
    logic [CFG_W-1:0]    cfg_wdata = '0;

    box_blur_3x3_edge_aware uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wen       (cfg_wen),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ---- blur model state -------------------------------------------------
    logic [WID_W-1:0]  geo_width = 11'd1;
    logic [HGT_W-1:0]  geo_height = 13'd1;
    logic [PIX_W-1:0]  row_above [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]  row_two_above [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]  win [9];        // row*3+col, row 2 current, col 2 newest
    int                pos_row = 0;
    int                pos_col = 0;

    blur_px_t          blurred_q [$];
    int                errors = 0;
    int                pixels_sent = 0;
    int                tx_idle_pct = 0;   // sender gap chance per request
    int                rx_idle_pct = 0;   // receiver stall chance per cycle
    int                quiet_cycles = 0;

    // mean of the in-frame part of the 3x3 block centered on win cell (cr,cc);
    // (r,c) is the frame position of win cell (2,2)
    function automatic blur_px_t blur_at(int cr, int cc, int r, int c);
        blur_px_t px;
        int       s_r, s_g, s_b, cnt;
        s_r = 0; s_g = 0; s_b = 0; cnt = 0;
        for (int i = cr - 1; i <= cr + 1; i++)
        begin
            if (i > 2 || r + i < 2)
                continue;
            for (int j = cc - 1; j <= cc + 1; j++)
            begin
                if (j > 2 || c + j < 2)
                    continue;
                s_r += win[i*3+j][23:16];
                s_g += win[i*3+j][15:8];
                s_b += win[i*3+j][7:0];
                cnt++;
            end
        end
        // round half up
        px.red   = CH_W'((2*s_r + cnt) / (2*cnt));
        px.green = CH_W'((2*s_g + cnt) / (2*cnt));
        px.blue  = CH_W'((2*s_b + cnt) / (2*cnt));
        px.row = '0; px.col = '0; px.run_last = 1'b0; px.frame_end = 1'b0;
        return px;
    endfunction

    // Advance the model by one accepted pixel and queue what it completes.
    task automatic blur_accept(input logic [PIX_W-1:0] tdata);
        int       w, h, r, c, total, n;
        logic     ul, ur, ll, lr;
        blur_px_t px;
        w = (geo_width == 0) ? 1 : (geo_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : geo_width;
        h = (geo_height == 0) ? 1 : (geo_height > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF
                                                                   : geo_height;
        r = pos_row;
        c = pos_col;
        for (int i = 0; i < 3; i++)
        begin
            win[i*3+0] = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = row_two_above[c];
        win[5] = row_above[c];
        // tdata is blue:green:red from the top, model word is R:G:B
        win[8] = {tdata[7:0], tdata[15:8], tdata[23:16]};
        row_two_above[c] = row_above[c];
        row_above[c] = win[8];

        ul = (r >= 1) && (c >= 1);
        ur = (r >= 1) && (c == w - 1);
        ll = (r == h - 1) && (c >= 1);
        lr = (r == h - 1) && (c == w - 1);
        total = ul + ur + ll + lr;
        n = 0;
        if (ul)
        begin
            px = blur_at(1, 1, r, c); px.row = r - 1; px.col = c - 1;
            n++; px.run_last = (n == total); blurred_q.push_back(px);
        end
        if (ur)
        begin
            px = blur_at(1, 2, r, c); px.row = r - 1; px.col = c;
            n++; px.run_last = (n == total); blurred_q.push_back(px);
        end
        if (ll)
        begin
            px = blur_at(2, 1, r, c); px.row = r; px.col = c - 1;
            n++; px.run_last = (n == total); blurred_q.push_back(px);
        end
        if (lr)
        begin
            px = blur_at(2, 2, r, c); px.row = r; px.col = c;
            px.run_last = 1'b1; px.frame_end = 1'b1; blurred_q.push_back(px);
        end

        if (c + 1 >= w)
        begin
            pos_col = 0;
            pos_row = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            pos_col = c + 1;
    endtask

    // ---- checking ---------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        blur_px_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (blurred_q.size() == 0)
                report_mismatch("unexpected result, col", m_axis_tdata[45:36], -1);
            else
            begin
                want = blurred_q.pop_front();
                if (m_axis_tdata[7:0] != want.red)
                    report_mismatch("red", m_axis_tdata[7:0], want.red);
                if (m_axis_tdata[15:8] != want.green)
                    report_mismatch("green", m_axis_tdata[15:8], want.green);
                if (m_axis_tdata[23:16] != want.blue)
                    report_mismatch("blue", m_axis_tdata[23:16], want.blue);
                if (m_axis_tdata[35:24] != want.row)
                    report_mismatch("row", m_axis_tdata[35:24], want.row);
                if (m_axis_tdata[45:36] != want.col)
                    report_mismatch("col", m_axis_tdata[45:36], want.col);
                if (m_axis_tlast != want.run_last)
                    report_mismatch("run_last", m_axis_tlast, want.run_last);
                if (m_axis_tuser != want.frame_end)
                    report_mismatch("frame_end", m_axis_tuser, want.frame_end);
            end
        end
    end

    // receiver stalls at random
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    // watchdog: a stretch with no handshake at all ends the run
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---- stimulus helpers -------------------------------------------------
    // one pixel request; tvalid is left high for a following request
    task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {blue, green, red};
        do
            @(posedge clk);
        while (!s_axis_tready);
        blur_accept(s_axis_tdata);
        pixels_sent++;
    endtask

    task automatic send_random_pixel();
        logic [7:0] ch [3];
        for (int k = 0; k < 3; k++)
        begin
            case ($urandom_range(9))
                0:       ch[k] = 8'd0;
                1:       ch[k] = 8'd255;
                default: ch[k] = 8'($urandom);
            endcase
        end
        send_pixel(ch[0], ch[1], ch[2]);
    endtask

    // drop tvalid, let every queued result out, then let the pipe settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (blurred_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // geometry write; any write restarts the frame
    task automatic write_geometry(input int width, input int height);
        cfg_wen   <= 1'b1;
        cfg_addr  <= REG_WIDTH;
        cfg_wdata <= CFG_W'(width);
        @(posedge clk);
        cfg_addr  <= REG_HEIGHT;
        cfg_wdata <= CFG_W'(height);
        @(posedge clk);
        cfg_wen   <= 1'b0;
        @(posedge clk);
        geo_width  = WID_W'(width);
        geo_height = HGT_W'(height);
        pos_row = 0;
        pos_col = 0;
    endtask

    // ---- tests ------------------------------------------------------------
    // 3x3 frame: corner, edge and interior counts, channel extremes
    task automatic test_small_frame();
        write_geometry(3, 3);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd128, 8'd1, 8'd254);
        send_pixel(8'd85, 8'd170, 8'd15);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd1, 8'd2, 8'd3);
        send_pixel(8'd0, 8'd0, 8'd0);
        wait_idle();
    endtask

    // one pixel per frame, and frames that are one column or one row wide
    task automatic test_thin_frames();
        write_geometry(1, 1);
        send_pixel(8'd200, 8'd7, 8'd99);
        send_pixel(8'd255, 8'd255, 8'd255);
        wait_idle();
        write_geometry(1, 3);
        repeat (3) send_random_pixel();
        wait_idle();
        write_geometry(4, 1);
        repeat (4) send_random_pixel();
        wait_idle();
    endtask

    // out-of-range geometry: zero acts as one, oversize clamps to the maximum
    task automatic test_clamped_geometry();
        write_geometry(0, 0);
        send_pixel(8'd17, 8'd34, 8'd51);
        send_pixel(8'd0, 8'd255, 8'd0);
        wait_idle();
        write_geometry(2047, 8191);
        repeat (3) send_random_pixel();
        wait_idle();
        write_geometry(MAX_WIDTH_DEF, MAX_HEIGHT_DEF);
        repeat (2) send_random_pixel();
        wait_idle();
    endtask

    // random geometry, whole frames back to back, some cut short
    task automatic test_random_frames(input int tx_pct, input int rx_pct);
        int target, w, h, frames, len;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target = pixels_sent + PHASE_ITEMS;
        while (pixels_sent < target)
        begin
            w = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            frames = $urandom_range(1, 2);
            len = w * h * frames;
            if ($urandom_range(9) == 0)
                len = $urandom_range(1, len);   // aborted frame
            if (len > target - pixels_sent)
                len = target - pixels_sent;
            write_geometry(w, h);
            repeat (len) send_random_pixel();
            wait_idle();
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_small_frame();
        test_thin_frames();
        test_clamped_geometry();
        test_random_frames(37, 79);
        test_random_frames(79, 37);
        test_random_frames(0, 0);

        wait_idle();
        if (blurred_q.size() != 0)
            report_mismatch("results left over", 0, blurred_q.size());
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
